// ===== hw/rtl/ppc_pkg.sv =====
// Shared constants, types and controller codes for the proximity contact block.
package ppc_pkg;

   localparam int MAX_PERSONS = 64;
   localparam int FRAME_BITS  = 12;
   localparam int COORD_BITS  = 16;
   localparam int DIST_BITS   = 16;
   localparam int IDX_BITS    = 6;
   localparam int SLOT_BITS   = $clog2(MAX_PERSONS);
   localparam int CNT_BITS    = $clog2(MAX_PERSONS) + 1;
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * IDX_BITS + FRAME_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_CONTACT_DISTANCE = CSR_ADDR_BITS'(0);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } ppc_state_type;

   typedef struct packed {
      logic load;
      logic scan_en;
      logic finish;
   } ppc_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic flush_ok;
   } ppc_status_type;

endpackage

// ===== hw/rtl/ppc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ppc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ppc_ctrl.sv =====
// Controller state machine that sequences load, scan and flush of one person.
module ppc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output ppc_pkg::ppc_cmd_type    cmd,
   input  ppc_pkg::ppc_status_type status
);
   import ppc_pkg::*;

   ppc_state_type state_ff;
   ppc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.flush_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ppc_dp.sv =====
// Datapath: position store, distance pipeline, pending contact and result register.
module ppc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ppc_pkg::ppc_cmd_type              cmd,
   output ppc_pkg::ppc_status_type           status,
   input  logic [ppc_pkg::COORD_BITS-1:0]    in_x,
   input  logic [ppc_pkg::COORD_BITS-1:0]    in_y,
   input  logic                              in_end,
   input  logic [ppc_pkg::DIST_BITS-1:0]     contact_distance,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [ppc_pkg::IDX_BITS-1:0]      out_first,
   output logic [ppc_pkg::IDX_BITS-1:0]      out_second,
   output logic [ppc_pkg::FRAME_BITS-1:0]    out_frame,
   output logic                              out_last
);
   import ppc_pkg::*;

   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 1;
   localparam int THR_BITS = 2 * DIST_BITS;

   // Frame and person bookkeeping.
   logic [CNT_BITS-1:0]   count_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic                  cap_ff;
   logic                  active_ff;
   logic                  end_ff;
   logic [SLOT_BITS-1:0]  me_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [THR_BITS-1:0]   thr2_ff;

   // Scan pipeline.
   logic [CNT_BITS-1:0]   issue_ff;
   logic                  s1_v_ff;
   logic [SLOT_BITS-1:0]  s1_idx_ff;
   logic                  s2_v_ff;
   logic [SLOT_BITS-1:0]  s2_idx_ff;
   logic [COORD_BITS-1:0] dx_ff;
   logic [COORD_BITS-1:0] dy_ff;
   logic                  s3_v_ff;
   logic [SLOT_BITS-1:0]  s3_idx_ff;
   logic [SQ_BITS-1:0]    sqx_ff;
   logic [SQ_BITS-1:0]    sqy_ff;

   // Contact held back until it is known whether it is the last one.
   logic                  pend_v_ff;
   logic [SLOT_BITS-1:0]  pend_idx_ff;

   logic                  out_v_ff;
   logic [IDX_BITS-1:0]   out_first_ff;
   logic [IDX_BITS-1:0]   out_second_ff;
   logic [FRAME_BITS-1:0] out_frame_ff;
   logic                  out_last_ff;

   logic                  cap;
   logic                  issuing;
   logic                  hit;
   logic                  out_free;
   logic                  out_load;
   logic                  adv;
   logic                  ram_we;
   logic [2*COORD_BITS-1:0] rdata;
   logic [COORD_BITS-1:0] sx;
   logic [COORD_BITS-1:0] sy;
   logic [SUM_BITS-1:0]   d2;

   assign cap      = (count_ff < CNT_BITS'(MAX_PERSONS));
   assign ram_we   = cmd.load && cap;
   assign out_free = !out_v_ff || out_ready;
   assign d2       = SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff);
   assign hit      = s3_v_ff && (d2 < SUM_BITS'(thr2_ff));
   assign adv      = cmd.scan_en && !(hit && pend_v_ff && !out_free);
   assign issuing  = active_ff && (issue_ff != CNT_BITS'(me_ff));
   assign sx       = rdata[COORD_BITS-1:0];
   assign sy       = rdata[2*COORD_BITS-1:COORD_BITS];
   // The pending contact moves to the result register when a newer hit
   // replaces it or when the person is finished.
   assign out_load = pend_v_ff && ((adv && hit) || cmd.finish);

   assign status.scan_done = !issuing && !s1_v_ff && !s2_v_ff && !s3_v_ff;
   assign status.flush_ok  = !pend_v_ff || out_free;

   ppc_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_PERSONS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[SLOT_BITS-1:0]),
      .wdata ({in_y, in_x}),
      .re    (adv),
      .raddr (issue_ff[SLOT_BITS-1:0]),
      .rdata (rdata)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         frame_ff  <= '0;
         active_ff <= 1'b0;
         issue_ff  <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_load || (out_v_ff && !out_ready);
         if (cmd.load) begin
            active_ff <= cap && (in_x != '0) && (in_y != '0);
            issue_ff  <= '0;
            s1_v_ff   <= 1'b0;
            s2_v_ff   <= 1'b0;
            s3_v_ff   <= 1'b0;
            pend_v_ff <= 1'b0;
         end
         if (adv) begin
            s1_v_ff <= issuing;
            if (issuing) begin
               issue_ff <= issue_ff + CNT_BITS'(1);
            end
            s2_v_ff <= s1_v_ff && (sx != '0) && (sy != '0);
            s3_v_ff <= s2_v_ff;
            if (hit) begin
               pend_v_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            if (pend_v_ff) begin
               pend_v_ff <= 1'b0;
            end
            if (end_ff) begin
               count_ff <= '0;
               frame_ff <= frame_ff + FRAME_BITS'(1);
            end else if (cap_ff) begin
               count_ff <= count_ff + CNT_BITS'(1);
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      thr2_ff <= THR_BITS'(contact_distance) * THR_BITS'(contact_distance);
      if (cmd.load) begin
         cap_ff <= cap;
         end_ff <= in_end;
         me_ff  <= count_ff[SLOT_BITS-1:0];
         x_ff   <= in_x;
         y_ff   <= in_y;
      end
      if (adv) begin
         s1_idx_ff <= issue_ff[SLOT_BITS-1:0];
         s2_idx_ff <= s1_idx_ff;
         dx_ff     <= (x_ff > sx) ? (x_ff - sx) : (sx - x_ff);
         dy_ff     <= (y_ff > sy) ? (y_ff - sy) : (sy - y_ff);
         s3_idx_ff <= s2_idx_ff;
         sqx_ff    <= SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
         sqy_ff    <= SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
         if (hit) begin
            pend_idx_ff <= s3_idx_ff;
            if (pend_v_ff) begin
               out_first_ff  <= IDX_BITS'(pend_idx_ff);
               out_second_ff <= IDX_BITS'(me_ff);
               out_frame_ff  <= frame_ff;
               out_last_ff   <= 1'b0;
            end
         end
      end
      if (cmd.finish && pend_v_ff) begin
         out_first_ff  <= IDX_BITS'(pend_idx_ff);
         out_second_ff <= IDX_BITS'(me_ff);
         out_frame_ff  <= frame_ff;
         out_last_ff   <= 1'b1;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_first  = out_first_ff;
   assign out_second = out_second_ff;
   assign out_frame  = out_frame_ff;
   assign out_last   = out_last_ff;

endmodule

// ===== hw/rtl/pairwise_proximity_contacts.sv =====
// Top level of the pairwise proximity contact finder with its register port.
// A tracked person at index n > 0 is finished after a scan that reads one stored position
// per cycle while the result side does not stall; any other person skips the comparisons.
// A new person is accepted only once the previous one is finished.
// Reset (synchronous, active high) empties the frame, zeroes the frame counter and
// the distance register; the position store is left as is and needs no clearing pass.
module pairwise_proximity_contacts (
   input  logic                                clock,
   input  logic                                reset,
   // Person transactions.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ppc_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // x_coord, y_coord
   input  logic                                req_tlast,  // frame_end
   // Contact transactions.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ppc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // first_person, second_person, frame_number
   output logic                                rsp_tlast,  // last_contact
   // Register port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ppc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ppc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ppc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import ppc_pkg::*;

   logic [DIST_BITS-1:0]  contact_distance_ff;
   logic                  csr_write;
   ppc_cmd_type           cmd;
   ppc_status_type        status;
   logic [IDX_BITS-1:0]   out_first;
   logic [IDX_BITS-1:0]   out_second;
   logic [FRAME_BITS-1:0] out_frame;

   // The register port never waits. A write lands on the access cycle; an
   // address outside the register list is ignored and reads as zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         contact_distance_ff <= '0;
      end else if (csr_write && (csr_paddr == CSR_CONTACT_DISTANCE)) begin
         contact_distance_ff <= csr_pwdata[DIST_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_CONTACT_DISTANCE) ?
                       CSR_DATA_BITS'(contact_distance_ff) : '0;

   // The controller accepts one person, lets the datapath scan every earlier
   // person of the frame, and then flushes the held-back final contact.
   ppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath keeps one contact pending so that the last one of a scan can
   // be marked; the result register lets the scan run on while it waits.
   ppc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_x             (req_tdata[COORD_BITS-1:0]),
      .in_y             (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .in_end           (req_tlast),
      .contact_distance (contact_distance_ff),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_first        (out_first),
      .out_second       (out_second),
      .out_frame        (out_frame),
      .out_last         (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'({out_frame, out_second, out_first});

   // Only one person is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second person accepted while one is in work");

   // The earlier person of a contact always has the lower index.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_first < out_second))
      else $error("contact pair out of order");

   // Finishing a person returns the block to accepting transactions.
   a_finish_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_tready)
      else $error("block not ready after finishing a person");

   // A register write takes effect on the next cycle.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_paddr == CSR_CONTACT_DISTANCE)) |=>
      (contact_distance_ff == $past(csr_pwdata[DIST_BITS-1:0])))
      else $error("distance register write lost");

endmodule

// ===== tb/sv/tb_pairwise_proximity_contacts.sv =====
// Self-checking testbench for the pairwise proximity contact finder.
module tb_pairwise_proximity_contacts;
   timeunit 1ns;
   timeprecision 1ps;

   import ppc_pkg::*;

   // Before a register write we wait past the last contact long enough for a
   // scan over a full frame to end, since persons that cause no contacts may
   // still be in the scan.
   localparam int DRAIN_CYCLES = MAX_PERSONS + 6 + 10;
   // Long hold-off of the contact side, so that the block fills up and must
   // push back on the person side.
   localparam int CHOKE_CYCLES = 400;
   localparam int RANDOM_ITEMS = 200;
   // Generous limit: every result waiting out the longest stall, several times over.
   localparam longint TIMEOUT_NS = 64'd25_000_000;
   // Register index 4 does not exist; writes to it must be dropped.
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNMAPPED = CSR_ADDR_BITS'(4);

   typedef struct packed {
      logic [IDX_BITS-1:0]   first_person;
      logic [IDX_BITS-1:0]   second_person;
      logic [FRAME_BITS-1:0] frame_number;
      logic                  last_contact;
   } contact_type;

   typedef enum logic [1:0] {
      ROW_PERSON,
      ROW_SET_DIST,
      ROW_SET_UNMAPPED
   } row_kind_type;

   // One row of the directed table. For ROW_SET_DIST the x field holds the
   // distance. A contact count of -1 leaves the row to the predictor alone.
   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  x;
      logic [15:0]  y;
      logic         frame_end;
      int           contacts;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 19;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // x_coord, y_coord
   logic                     req_tlast = 1'b0; // frame_end
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // first_person, second_person, frame_number
   logic                     rsp_tlast;        // last_contact
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Shadow state of the block: positions seen in this frame, the frame
   // counter and the distance register.
   logic [31:0]           seen_positions [MAX_PERSONS];
   int                    persons_in_frame = 0;
   logic [FRAME_BITS-1:0] frame_now = '0;
   logic [DIST_BITS-1:0]  dist_now = '0;

   contact_type pending_contacts [$];
   int          mismatch_count = 0;
   bit          steady_send = 1'b0;
   bit          choke_request = 1'b0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // Reset value of the distance register, read back after a dropped write.
      '{ROW_SET_UNMAPPED, 16'd0,     16'd0,     1'b0,  0},
      // Distance zero after reset: even coinciding persons are no contact.
      '{ROW_PERSON,       16'd1,     16'd1,     1'b0,  0},
      '{ROW_PERSON,       16'd1,     16'd1,     1'b1,  0},
      '{ROW_SET_DIST,     16'hFFFF,  16'd0,     1'b0,  0},
      // Corners of the coordinate range at the largest distance.
      '{ROW_PERSON,       16'hFFFF,  16'hFFFF,  1'b0,  0},
      '{ROW_PERSON,       16'd1,     16'd1,     1'b0,  0},
      '{ROW_PERSON,       16'hFFFF,  16'd1,     1'b0,  2},
      // Absent persons take an index but are never compared.
      '{ROW_PERSON,       16'd0,     16'd500,   1'b0,  0},
      '{ROW_PERSON,       16'd500,   16'd0,     1'b0,  0},
      '{ROW_PERSON,       16'd0,     16'd0,     1'b0,  0},
      '{ROW_PERSON,       16'h8000,  16'h8000,  1'b1, -1},
      '{ROW_SET_UNMAPPED, 16'd0,     16'd0,     1'b0,  0},
      '{ROW_PERSON,       16'd100,   16'd100,   1'b0,  0},
      '{ROW_PERSON,       16'd100,   16'd100,   1'b0,  1},
      // Distance one: only coinciding persons touch; a unit step does not.
      '{ROW_SET_DIST,     16'd1,     16'd0,     1'b0,  0},
      '{ROW_PERSON,       16'd100,   16'd100,   1'b0,  2},
      '{ROW_PERSON,       16'd101,   16'd100,   1'b0,  0},
      '{ROW_PERSON,       16'd100,   16'd100,   1'b1,  3},
      // A frame made of one absent person.
      '{ROW_PERSON,       16'd0,     16'd0,     1'b1,  0}
   };

   pairwise_proximity_contacts uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("Mismatch at %0t: %s", $time, what);
      end
   endtask

   // Works out the contacts one accepted person causes and queues them.
   // The new person is compared with every earlier present person of the
   // frame in index order; a contact needs dx^2 + dy^2 below distance^2.
   task automatic predict_contacts(input logic [15:0] x, input logic [15:0] y,
                                   input logic frame_end, output int hits);
      logic [63:0] limit_sq;
      logic [63:0] dx;
      logic [63:0] dy;
      logic [15:0] sx;
      logic [15:0] sy;
      logic [IDX_BITS-1:0] hit_list [$];
      contact_type found;
      int k;
      hits = 0;
      limit_sq = 64'(dist_now) * 64'(dist_now);
      // A full frame ignores further persons; only the frame mark still acts.
      if (persons_in_frame < MAX_PERSONS) begin
         if (x != 0 && y != 0) begin
            for (k = 0; k < persons_in_frame; k++) begin
               sx = seen_positions[k][15:0];
               sy = seen_positions[k][31:16];
               if (sx != 0 && sy != 0) begin
                  dx = (x > sx) ? 64'(x - sx) : 64'(sx - x);
                  dy = (y > sy) ? 64'(y - sy) : 64'(sy - y);
                  if (dx * dx + dy * dy < limit_sq) begin
                     hit_list = {hit_list, IDX_BITS'(k)};
                  end
               end
            end
         end
         for (k = 0; k < hit_list.size(); k++) begin
            found.first_person  = hit_list[k];
            found.second_person = IDX_BITS'(persons_in_frame);
            found.frame_number  = frame_now;
            found.last_contact  = (k == hit_list.size() - 1);
            pending_contacts = {pending_contacts, found};
         end
         hits = hit_list.size();
         seen_positions[persons_in_frame] = {y, x};
         persons_in_frame++;
      end
      // The frame mark closes the frame after this person's comparisons.
      if (frame_end) begin
         persons_in_frame = 0;
         frame_now = frame_now + 1'b1;
      end
   endtask

   // Offers one person and waits for the handshake, then idles at random.
   // With no idle gap the valid stays high into the next transaction.
   task automatic send_person(input logic [15:0] x, input logic [15:0] y,
                              input logic frame_end, output int hits);
      int gap;
      int roll;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({y, x});
      req_tlast  <= frame_end;
      do @(posedge clock); while (!req_tready);
      predict_contacts(x, y, frame_end, hits);
      roll = $urandom_range(0, 99);
      if (steady_send || roll < 45) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 95) gap = $urandom_range(4, 8);
      else gap = $urandom_range(15, 40);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stops offering persons and waits until the block has gone quiet.
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register port transaction: a setup cycle, then an access cycle that
   // completes at the rising edge where pready is high.
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr && addr == CSR_CONTACT_DISTANCE) begin
         dist_now = wdata[DIST_BITS-1:0];
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes a register while the block is idle and reads the distance back.
   task automatic program_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                   input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      settle_block();
      csr_access(1'b1, addr, value, readback);
      csr_access(1'b0, CSR_CONTACT_DISTANCE, CSR_DATA_BITS'($urandom), readback);
      if (readback[DIST_BITS-1:0] !== dist_now) begin
         flag_mismatch($sformatf("distance register read %0d, expected %0d",
                                 readback[DIST_BITS-1:0], dist_now));
      end
   endtask

   // A coordinate scattered around a center, kept inside the present range.
   function automatic logic [15:0] near(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 1) v = 1;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // Every accepted contact transaction is checked against the oldest
   // expectation. Sampling happens at the rising edge, before the block's
   // registers update in the same time step.
   always @(posedge clock) begin
      contact_type want;
      contact_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.first_person  = rsp_tdata[IDX_BITS-1:0];
         got.second_person = rsp_tdata[2*IDX_BITS-1:IDX_BITS];
         got.frame_number  = rsp_tdata[2*IDX_BITS+FRAME_BITS-1:2*IDX_BITS];
         got.last_contact  = rsp_tlast;
         if (pending_contacts.size() == 0) begin
            flag_mismatch($sformatf("contact %0d-%0d frame %0d with none expected",
                                    got.first_person, got.second_person,
                                    got.frame_number));
         end else begin
            want = pending_contacts.pop_front();
            if (got.first_person !== want.first_person ||
                got.second_person !== want.second_person ||
                got.frame_number !== want.frame_number ||
                got.last_contact !== want.last_contact) begin
               flag_mismatch($sformatf(
                  "contact expected %0d-%0d frame %0d last %0b, got %0d-%0d frame %0d last %0b",
                  want.first_person, want.second_person, want.frame_number,
                  want.last_contact, got.first_person, got.second_person,
                  got.frame_number, got.last_contact));
            end
         end
      end
   end

   // Contact side: mostly ready, short and occasional long stalls, stretches
   // of steady readiness, and one long hold-off when the stimulus asks for it.
   initial begin : contact_sink
      int stall_left;
      bit steady;
      stall_left = 0;
      steady = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) steady = !steady;
         if (choke_request) begin
            rsp_tready <= 1'b0;
            repeat (CHOKE_CYCLES - 1) @(negedge clock);
            choke_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (steady || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
         end
      end
   end

   initial begin : time_limit
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int r;
      int i;
      int phase;
      int frame_len;
      int phase_items;
      int hits;
      int spread;
      int cx;
      int cy;
      bit clustered;
      bit long_done;
      bit forced_long;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] phase_dist [4];

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: register extremes, coordinate corners, absent persons
      // and dropped register writes, walked row by row.
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         case (directed_rows[r].kind)
            ROW_SET_DIST: begin
               program_register(CSR_CONTACT_DISTANCE,
                                {16'($urandom), directed_rows[r].x});
            end
            ROW_SET_UNMAPPED: begin
               program_register(CSR_UNMAPPED, CSR_DATA_BITS'($urandom));
            end
            default: begin
               send_person(directed_rows[r].x, directed_rows[r].y,
                           directed_rows[r].frame_end, hits);
               if (directed_rows[r].contacts >= 0 && hits != directed_rows[r].contacts) begin
                  flag_mismatch($sformatf("row %0d predicts %0d contacts, table says %0d",
                                          r, hits, directed_rows[r].contacts));
               end
            end
         endcase
      end

      // Random part in four settings of the distance: the largest, a
      // moderate one, zero and a fully random one. Most frames are short and
      // clustered so that contacts are frequent; one frame overruns capacity.
      phase_dist[0] = 16'hFFFF;
      phase_dist[1] = 16'($urandom_range(16, 2000));
      phase_dist[2] = 16'h0000;
      phase_dist[3] = 16'($urandom);
      long_done = 1'b0;
      for (phase = 0; phase < 4; phase++) begin
         program_register(CSR_CONTACT_DISTANCE, {16'($urandom), phase_dist[phase]});
         // Hold the contact side off while persons keep coming, so the
         // block backs up into its person input.
         if (phase == 0) choke_request = 1'b1;
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / 4) begin
            forced_long = 1'b0;
            if (phase == 1 && !long_done) begin
               frame_len = MAX_PERSONS + 3;
               long_done = 1'b1;
               forced_long = 1'b1;
            end else if ($urandom_range(0, 11) == 0) begin
               frame_len = $urandom_range(MAX_PERSONS, MAX_PERSONS + 6);
            end else begin
               frame_len = $urandom_range(1, 8);
            end
            // Keep each phase close to its share of the items.
            if (!forced_long && frame_len > RANDOM_ITEMS / 4 - phase_items) begin
               frame_len = RANDOM_ITEMS / 4 - phase_items;
            end
            steady_send = ($urandom_range(0, 3) == 0);
            clustered = ($urandom_range(0, 3) != 0);
            spread = int'(dist_now) + 4;
            cx = $urandom_range(1, 65535);
            cy = $urandom_range(1, 65535);
            for (i = 0; i < frame_len; i++) begin
               if (clustered) begin
                  px = near(cx, spread);
                  py = near(cy, spread);
               end else begin
                  px = 16'($urandom_range(1, 65535));
                  py = 16'($urandom_range(1, 65535));
               end
               // A few persons are not tracked in one or both coordinates.
               case ($urandom_range(0, 19))
                  0: px = 16'd0;
                  1: py = 16'd0;
                  2: begin
                     px = 16'd0;
                     py = 16'd0;
                  end
                  default: ;
               endcase
               send_person(px, py, i == frame_len - 1, hits);
               phase_items++;
            end
         end
      end

      // Let every expected contact arrive, then give the block time to show
      // any contact it should not produce.
      settle_block();
      if (mismatch_count == 0 && pending_contacts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_ram.sv
hw/rtl/ppc_ctrl.sv
hw/rtl/ppc_dp.sv
hw/rtl/pairwise_proximity_contacts.sv
tb/sv/tb_pairwise_proximity_contacts.sv
